/* hw/rtl/lz_word_decompressor_macros.svh */
// Assertion macros for the word decompressor.
`ifndef LZ_WORD_DECOMPRESSOR_MACROS_SVH
`define LZ_WORD_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS
`define LZWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LZWD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define LZWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LZWD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* hw/rtl/lzwd_pkg.sv */
// Shared types and constants for the word decompressor.
package lzwd_pkg;

  localparam int WORD_W    = 16;
  localparam int OFF_W     = 11;
  localparam int WIN_DEPTH = 2048;
  localparam int WIN_AW    = 11;
  localparam int RUN_W     = 17;
  localparam int BITS_W    = 5;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // What the back end does with a queued item.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LIT  = 2'd1,
    OP_COPY = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
    logic [OFF_W-1:0]  offset;
    logic              wants;
    logic              finished;
    logic              misplaced;
  } qitem_t;

  typedef struct packed {
    logic              word_valid;
    logic [WORD_W-1:0] word;
    logic              wants;
    logic              finished;
    logic              misplaced;
  } result_t;

endpackage

/* hw/rtl/lzwd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lzwd_front.sv */
// Front end: parses commands and source words, classifies each into a queue item.
module lzwd_front
  import lzwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        command,
  input  logic [WORD_W-1:0] source_word,
  output qitem_t            item
);

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_ITEM  = 3'd1,
    PH_COUNT = 3'd2,
    PH_RUN   = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [WORD_W-1:0]  flag_r, flag_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [RUN_W-1:0]   cnt_r, cnt_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;

  logic [BITS_W-1:0]  bits_dec;
  logic [RUN_W-1:0]   cnt_dec;
  logic               take;
  op_t                op;
  logic [WORD_W-1:0]  lit;
  logic [OFF_W-1:0]   copy_off;
  logic               misplaced;

  assign bits_dec = bits_r - BITS_W'(1);
  assign cnt_dec  = cnt_r - RUN_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    take      = 1'b0;
    op        = OP_NONE;
    lit       = '0;
    copy_off  = off_r;
    misplaced = 1'b0;

    unique case (cmd_t'(command))
      CMD_PUSH: begin
        unique case (phase_r)
          PH_FLAG: begin
            flag_nxt  = source_word;
            bits_nxt  = BITS_W'(WORD_W);
            phase_nxt = PH_ITEM;
          end
          PH_ITEM: begin
            if (!flag_r[WORD_W-1]) begin
              op   = OP_LIT;
              lit  = source_word;
              take = 1'b1;
            end else begin
              off_nxt   = source_word[OFF_W-1:0];
              cnt_nxt   = RUN_W'(source_word[WORD_W-1:OFF_W]);
              phase_nxt = (source_word[WORD_W-1:OFF_W] != '0) ? PH_RUN : PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (source_word == '0 && off_r == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              // long count of zero means a full 65536-word run
              cnt_nxt   = (source_word == '0) ? {1'b1, {WORD_W{1'b0}}}
                                              : {1'b0, source_word};
              phase_nxt = PH_RUN;
            end
          end
          default: begin
            misplaced = 1'b1;
          end
        endcase
      end
      CMD_ADVANCE: begin
        if (phase_r == PH_RUN) begin
          // offset zero is a zero fill, no history read
          op      = (off_r == '0) ? OP_LIT : OP_COPY;
          cnt_nxt = cnt_dec;
          take    = (cnt_dec == '0);
        end
      end
      CMD_RESTART: begin
        phase_nxt = PH_FLAG;
        flag_nxt  = '0;
        bits_nxt  = '0;
        cnt_nxt   = '0;
        off_nxt   = '0;
      end
      default: ;
    endcase

    if (take) begin
      flag_nxt  = {flag_r[WORD_W-2:0], 1'b0};
      bits_nxt  = bits_dec;
      phase_nxt = (bits_dec == '0) ? PH_FLAG : PH_ITEM;
    end
  end

  always_comb begin
    item.op        = op;
    item.word      = lit;
    item.offset    = copy_off;
    item.wants     = (phase_nxt == PH_FLAG) || (phase_nxt == PH_ITEM) ||
                     (phase_nxt == PH_COUNT);
    item.finished  = (phase_nxt == PH_DONE);
    item.misplaced = misplaced;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      flag_r  <= '0;
      bits_r  <= '0;
      cnt_r   <= '0;
      off_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      bits_r  <= bits_nxt;
      cnt_r   <= cnt_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

/* hw/rtl/lzwd_queue.sv */
// Short FIFO of classified items between front and back end.
module lzwd_queue
  import lzwd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output qitem_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qitem_t        slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/lzwd_back.sv */
// Back end: history window read/write, word emission and output register.
module lzwd_back
  import lzwd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  qitem_t  head,
  output logic    pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  // Stage B: item whose history read is in flight
  logic              b_valid_r;
  qitem_t            b_item_r;
  logic [WIN_AW-1:0] b_waddr_r;
  logic              b_rd_ok_r;
  logic              b_byp_r;
  logic [WORD_W-1:0] b_byp_data_r;

  logic [WIN_AW-1:0] wp_r;
  logic [WIN_AW:0]   fill_r;   // words written so far, saturates at window size

  logic              out_valid_r;
  result_t           out_r;

  logic              b_adv;
  logic              b_emit;
  logic              head_emit;
  logic [WIN_AW-1:0] raddr;
  logic              rd_ok;
  logic              byp;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] b_word;

  assign b_adv     = b_valid_r && (!out_valid_r || res_ready);
  assign pop       = head_valid && (!b_valid_r || b_adv);
  assign b_emit    = (b_item_r.op != OP_NONE);
  assign head_emit = (head.op != OP_NONE);

  assign raddr = wp_r - head.offset;
  // never-written entries read as zero
  assign rd_ok = fill_r[WIN_AW] || (raddr < fill_r[WIN_AW-1:0]);
  // the word stage B writes this cycle is not yet in the RAM
  assign byp   = b_valid_r && b_emit && (raddr == b_waddr_r);

  always_comb begin
    case (b_item_r.op)
      OP_LIT:  b_word = b_item_r.word;
      OP_COPY: b_word = b_byp_r ? b_byp_data_r : (b_rd_ok_r ? rdata : '0);
      default: b_word = '0;
    endcase
  end

  lzwd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (b_adv && b_emit),
    .waddr (b_waddr_r),
    .wdata (b_word),
    .re    (pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r     <= head;
      b_waddr_r    <= wp_r;
      b_rd_ok_r    <= rd_ok;
      b_byp_r      <= byp;
      b_byp_data_r <= b_word;
    end
    if (b_adv) begin
      out_r.word_valid <= b_emit;
      out_r.word       <= b_word;
      out_r.wants      <= b_item_r.wants;
      out_r.finished   <= b_item_r.finished;
      out_r.misplaced  <= b_item_r.misplaced;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      fill_r      <= '0;
    end else begin
      if (pop) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop && head_emit) begin
        wp_r <= wp_r + WIN_AW'(1);
        if (!fill_r[WIN_AW]) begin
          fill_r <= fill_r + (WIN_AW+1)'(1);
        end
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

/* hw/rtl/lz_word_decompressor.sv */
// Path of an item: queue, stage B window read, output register, then offered as a result.
// Throughput: one item per cycle; a result follows every item, stalls come only from out_ready.
// The history window is one 2048-word RAM, one read and one write per cycle.
// Reset: synchronous, active low; clears parse state, queue, pointers and the fill count.
// The window is not swept: entries never written read as zero via the fill count.
`include "lz_word_decompressor_macros.svh"

module lz_word_decompressor
  import lzwd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [WORD_W-1:0] in_source_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_out_valid,
  output logic [WORD_W-1:0] out_out_word,
  output logic              out_wants_word,
  output logic              out_finished,
  output logic              out_misplaced_push
);

  logic    q_full;
  logic    accept;
  qitem_t  front_item;
  logic    q_pop;
  logic    q_head_valid;
  qitem_t  q_head;
  result_t res;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  lzwd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .source_word (in_source_word),
    .item        (front_item)
  );

  lzwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  lzwd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_out_valid      = res.word_valid;
  assign out_out_word       = res.word;
  assign out_wants_word     = res.wants;
  assign out_finished       = res.finished;
  assign out_misplaced_push = res.misplaced;

  `LZWD_ASSERT_IMPLY(a_idle_word_zero, clk, rst_n, out_valid && !out_out_valid, out_out_word == '0, "word nonzero without word valid")
  `LZWD_ASSERT_NEVER(a_done_not_waiting, clk, rst_n, out_valid && out_finished && out_wants_word, "finished while still wanting words")
  `LZWD_ASSERT_IMPLY(a_misplaced_no_word, clk, rst_n, out_valid && out_misplaced_push, !out_out_valid, "ignored push produced a word")

endmodule
